FILE: rtl/ptw_pkg.sv
package ptw_pkg;

	// Result kinds
	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_FAULT   = 2'd2;

	// Fault codes
	localparam logic [2:0] ERR_BAD_ROOT      = 3'd0;
	localparam logic [2:0] ERR_NON_CANONICAL = 3'd1;
	localparam logic [2:0] ERR_NOT_PRESENT   = 3'd2;
	localparam logic [2:0] ERR_BAD_ENTRY     = 3'd3;
	localparam logic [2:0] ERR_READ          = 3'd4;

	// Page sizes
	localparam logic [1:0] PSIZE_4K = 2'd0;
	localparam logic [1:0] PSIZE_2M = 2'd1;
	localparam logic [1:0] PSIZE_1G = 2'd2;

	// Operations
	localparam logic OP_START    = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	// Register indexes
	localparam logic CFG_FIVE_LEVEL = 1'b0;
	localparam logic CFG_PA_BITS    = 1'b1;

	localparam int PA_W     = 52;
	localparam int CONTIG_W = 31;

	localparam logic [7:0] PA_BITS_MIN   = 8'd36;
	localparam logic [7:0] PA_BITS_MAX   = 8'd52;
	localparam logic [7:0] PA_BITS_RESET = 8'd52;

	// Entry bit positions
	localparam int PTE_P  = 0;
	localparam int PTE_RW = 1;
	localparam int PTE_US = 2;
	localparam int PTE_PS = 7;
	localparam int PTE_NX = 63;

	localparam logic [CONTIG_W-1:0] BYTES_4K = 31'h0000_1000;
	localparam logic [CONTIG_W-1:0] BYTES_2M = 31'h0020_0000;
	localparam logic [CONTIG_W-1:0] BYTES_1G = 31'h4000_0000;

	typedef struct packed {
		logic        operation;
		logic [63:0] virtual_address;
		logic [63:0] root_table;
		logic [63:0] entry_data;
		logic        read_error;
	} item_t;

	typedef struct packed {
		logic [1:0]          result_kind;
		logic [PA_W-1:0]     read_address;
		logic [PA_W-1:0]     physical_address;
		logic [1:0]          page_size;
		logic [CONTIG_W-1:0] contiguous_bytes;
		logic                writable;
		logic                user_ok;
		logic                executable;
		logic [2:0]          error_code;
		logic [2:0]          fault_level;
	} result_t;

	// Physical address mask: width clamped to 36..52, page offset bits cleared
	function automatic logic [PA_W-1:0] addr_mask(input logic [7:0] pa_bits);
		logic [7:0] bits;
		logic [PA_W-1:0] ones;
		bits = pa_bits;
		if (bits < PA_BITS_MIN) bits = PA_BITS_MIN;
		if (bits > PA_BITS_MAX) bits = PA_BITS_MAX;
		ones = ~({PA_W{1'b1}} << bits[5:0]);
		return ones & ~{{(PA_W-12){1'b0}}, 12'hFFF};
	endfunction

endpackage

FILE: rtl/ptw_in_reg.sv
module ptw_in_reg import ptw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// Stage takes a new word when empty or when the held word moves on
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/ptw_core.sv
module ptw_core import ptw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       five_level,
	input  logic [7:0] pa_bits,
	input  item_t      item_s1,
	input  logic       advance,
	output logic       has_result,
	output result_t    result
);

	logic [2:0]      level_q, nxt_level;
	logic [PA_W-1:0] table_q, nxt_table;
	logic [63:0]     va_q, nxt_va;
	logic            wr_q, user_q, exec_q;
	logic            nxt_wr, nxt_user, nxt_exec;

	logic [PA_W-1:0] mask;
	logic [PA_W-1:0] entry_base;
	logic            canon;
	logic            do_req;
	logic [8:0]      idx;

	assign mask       = addr_mask(pa_bits);
	assign entry_base = item_s1.entry_data[PA_W-1:0] & mask;

	// Sign extension check above bit 47 or bit 56
	always_comb begin
		if (five_level) begin
			canon = (&item_s1.virtual_address[63:56]) || !(|item_s1.virtual_address[63:56]);
		end else begin
			canon = (&item_s1.virtual_address[63:47]) || !(|item_s1.virtual_address[63:47]);
		end
	end

	// One walk step
	always_comb begin
		result     = '0;
		has_result = 1'b0;
		do_req     = 1'b0;
		nxt_level  = level_q;
		nxt_table  = table_q;
		nxt_va     = va_q;
		nxt_wr     = wr_q;
		nxt_user   = user_q;
		nxt_exec   = exec_q;
		if (item_s1.operation == OP_START) begin
			if (level_q == 3'd0) begin
				has_result = 1'b1;
				if (item_s1.root_table == 64'd0) begin
					result.result_kind = KIND_FAULT;
					result.error_code  = ERR_BAD_ROOT;
				end else if (!canon) begin
					result.result_kind = KIND_FAULT;
					result.error_code  = ERR_NON_CANONICAL;
				end else begin
					do_req    = 1'b1;
					nxt_va    = item_s1.virtual_address;
					nxt_table = item_s1.root_table[PA_W-1:0] & mask;
					nxt_wr    = 1'b1;
					nxt_user  = 1'b1;
					nxt_exec  = 1'b1;
					nxt_level = five_level ? 3'd5 : 3'd4;
				end
			end
		end else if (level_q != 3'd0) begin
			has_result = 1'b1;
			nxt_wr   = wr_q & item_s1.entry_data[PTE_RW];
			nxt_user = user_q & item_s1.entry_data[PTE_US];
			nxt_exec = exec_q & !item_s1.entry_data[PTE_NX];
			result.writable   = nxt_wr;
			result.user_ok    = nxt_user;
			result.executable = nxt_exec;
			if (item_s1.read_error) begin
				result             = '0;
				result.result_kind = KIND_FAULT;
				result.error_code  = ERR_READ;
				result.fault_level = level_q;
			end else if (!item_s1.entry_data[PTE_P]) begin
				result             = '0;
				result.result_kind = KIND_FAULT;
				result.error_code  = ERR_NOT_PRESENT;
				result.fault_level = level_q;
			end else if (level_q == 3'd1) begin
				result.result_kind      = KIND_DONE;
				result.page_size        = PSIZE_4K;
				result.physical_address = {entry_base[PA_W-1:12], va_q[11:0]};
				result.contiguous_bytes = BYTES_4K - {19'd0, va_q[11:0]};
			end else if (item_s1.entry_data[PTE_PS] && level_q == 3'd3) begin
				result.result_kind      = KIND_DONE;
				result.page_size        = PSIZE_1G;
				result.physical_address = {entry_base[PA_W-1:30], va_q[29:0]};
				result.contiguous_bytes = BYTES_1G - {1'b0, va_q[29:0]};
			end else if (item_s1.entry_data[PTE_PS] && level_q == 3'd2) begin
				result.result_kind      = KIND_DONE;
				result.page_size        = PSIZE_2M;
				result.physical_address = {entry_base[PA_W-1:21], va_q[20:0]};
				result.contiguous_bytes = BYTES_2M - {10'd0, va_q[20:0]};
			end else if (item_s1.entry_data[PTE_PS] || entry_base == '0) begin
				// large page at level 5 or 4, or a null next table
				result             = '0;
				result.result_kind = KIND_FAULT;
				result.error_code  = ERR_BAD_ENTRY;
				result.fault_level = level_q;
			end else begin
				do_req    = 1'b1;
				nxt_table = entry_base;
				nxt_level = level_q - 3'd1;
			end
			if (!do_req) begin
				nxt_level = 3'd0;
			end
		end

		// Entry read request for the new level
		unique case (nxt_level)
			3'd1:    idx = nxt_va[20:12];
			3'd2:    idx = nxt_va[29:21];
			3'd3:    idx = nxt_va[38:30];
			3'd4:    idx = nxt_va[47:39];
			3'd5:    idx = nxt_va[56:48];
			default: idx = 9'd0;
		endcase
		if (do_req) begin
			result              = '0;
			result.result_kind  = KIND_REQUEST;
			result.read_address = {nxt_table[PA_W-1:12], idx, 3'b000};
		end
	end

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 3'd0;
			table_q <= '0;
			va_q    <= '0;
			wr_q    <= 1'b1;
			user_q  <= 1'b1;
			exec_q  <= 1'b1;
		end else if (advance) begin
			level_q <= nxt_level;
			table_q <= nxt_table;
			va_q    <= nxt_va;
			wr_q    <= nxt_wr;
			user_q  <= nxt_user;
			exec_q  <= nxt_exec;
		end
	end

endmodule

FILE: rtl/ptw_out_reg.sv
module ptw_out_reg import ptw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic valid_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Result word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= load_data;
		end
	end

endmodule

FILE: rtl/page_table_walker.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    operation .. read_error
// out      output     out_valid/out_ready  result_kind .. fault_level
// cfg      input      cfg_write            cfg_index, cfg_data
//
// One input word per cycle unless stalled by a full result register; a word
// with a result goes: input register, one step logic pass, result register.
// Walk state updates as the word leaves the input register.
// Reset clears the walk to idle and the registers to four-level, 52-bit width.
// A full result register stalls only words that produce a result.
module page_table_walker import ptw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [63:0]         virtual_address,
	input  logic [63:0]         root_table,
	input  logic [63:0]         entry_data,
	input  logic                read_error,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          result_kind,
	output logic [PA_W-1:0]     read_address,
	output logic [PA_W-1:0]     physical_address,
	output logic [1:0]          page_size,
	output logic [CONTIG_W-1:0] contiguous_bytes,
	output logic                writable,
	output logic                user_ok,
	output logic                executable,
	output logic [2:0]          error_code,
	output logic [2:0]          fault_level,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	logic       five_level_q;
	logic [7:0] pa_bits_q;

	item_t   in_item, item_s1;
	logic    valid_s1, advance, has_result, space;
	result_t step_res, out_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			five_level_q <= 1'b0;
			pa_bits_q    <= PA_BITS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FIVE_LEVEL: five_level_q <= cfg_data[0];
				CFG_PA_BITS:    pa_bits_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign in_item.operation       = operation;
	assign in_item.virtual_address = virtual_address;
	assign in_item.root_table      = root_table;
	assign in_item.entry_data      = entry_data;
	assign in_item.read_error      = read_error;

	// Word moves on unless its result finds the output full
	assign advance = valid_s1 && (!has_result || space);

	ptw_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ptw_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.five_level (five_level_q),
		.pa_bits    (pa_bits_q),
		.item_s1    (item_s1),
		.advance    (advance),
		.has_result (has_result),
		.result     (step_res)
	);

	ptw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.load_data (step_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign result_kind      = out_res.result_kind;
	assign read_address     = out_res.read_address;
	assign physical_address = out_res.physical_address;
	assign page_size        = out_res.page_size;
	assign contiguous_bytes = out_res.contiguous_bytes;
	assign writable         = out_res.writable;
	assign user_ok          = out_res.user_ok;
	assign executable       = out_res.executable;
	assign error_code       = out_res.error_code;
	assign fault_level      = out_res.fault_level;

endmodule
